// ===== src/pbts_pkg.sv =====
package pbts_pkg;

  // Field and register widths
  localparam int SYS_W     = 28;
  localparam int FREQ_W    = 20;
  localparam int QUOT_W    = SYS_W - 2;   // timer clock is system clock / 4
  localparam int PCT_W     = 7;
  localparam int SQ_W      = 2 * PCT_W;
  localparam int EXP_W     = 3;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = SYS_W;

  // Default counter width of the timer
  localparam int DEF_COUNTER_BITS = 16;

  // Percent scale and prescaler search bound
  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
  localparam int PRESCALE_LIMIT = 129;

  function automatic int exp_count();
    int n;
    n = 0;
    while ((1 << n) < PRESCALE_LIMIT) n++;
    return n;
  endfunction

  localparam int EXP_COUNT = exp_count();

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FREQ  = 2'd1;
  localparam logic [SYS_W-1:0]  SYS_CLOCK_RESET = 28'd48000000;
  localparam logic [FREQ_W-1:0] OUT_FREQ_RESET  = 20'd1000;

  // Long division sequencer
  localparam int CNT_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    SEQ_LOAD,
    SEQ_DIV_FREQ,
    SEQ_SELECT,
    SEQ_DIV_HUND,
    SEQ_STORE,
    SEQ_IDLE
  } seq_state_t;

  // Timer selection handed from the setup engine to the request pipeline
  typedef struct packed {
    logic             busy;
    logic             err;
    logic [EXP_W-1:0] exp;
  } sel_info_t;

  // Divide by 100 through a reciprocal, exact for inputs below 2^14
  localparam int RECIP_SHIFT = 21;
  localparam logic [14:0] RECIP_100 = 15'd20972;

  function automatic logic [PCT_W-1:0] div100(input logic [SQ_W-1:0] x);
    logic [SQ_W+14:0] prod;
    prod = (SQ_W + 15)'(x) * (SQ_W + 15)'(RECIP_100);
    return PCT_W'(prod >> RECIP_SHIFT);
  endfunction

endpackage

// ===== src/pbts_setup.sv =====
module pbts_setup import pbts_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS,
  localparam int STEP_W = (COUNTER_BITS < QUOT_W) ? COUNTER_BITS : QUOT_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output sel_info_t            sel,
  output logic [STEP_W-1:0]    steps,
  output logic [STEP_W-1:0]    steps_hi,
  output logic [PCT_W-1:0]     steps_lo
);

  localparam int CMP_W = (COUNTER_BITS + 1 > QUOT_W) ? COUNTER_BITS + 1 : QUOT_W;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'((64'd1 << COUNTER_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

  // Divide by 100 through a reciprocal, exact for inputs below 2^QUOT_W
  localparam int HUND_SHIFT = 32;
  localparam logic [QUOT_W-1:0] HUND_RECIP = QUOT_W'(42949673);

  seq_state_t state_r, state_nxt;

  logic [SYS_W-1:0]  sysclk_r;
  logic [FREQ_W-1:0] freq_r;
  logic [QUOT_W-1:0] quo_r;
  logic [FREQ_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              err_r;
  logic [EXP_W-1:0]  exp_r;
  logic [STEP_W-1:0] steps_r;
  logic [STEP_W-1:0] hi_r;
  logic [PCT_W-1:0]  lo_r;

  logic              cfg_hit;
  logic [FREQ_W-1:0] divisor;
  logic [FREQ_W:0]   trial;
  logic              fits;
  logic [FREQ_W-1:0] rem_nxt;
  logic              found;
  logic [EXP_W-1:0]  exp_sel;
  logic [STEP_W-1:0] steps_sel;
  logic [2*QUOT_W-1:0] hund_prod;
  logic [STEP_W-1:0] hund_part;
  logic [STEP_W-1:0] hund_rem;

  assign cfg_hit = cfg_valid &&
                   (cfg_index == REG_SYSTEM_CLOCK || cfg_index == REG_OUTPUT_FREQ);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sysclk_r <= SYS_CLOCK_RESET;
      freq_r   <= OUT_FREQ_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SYSTEM_CLOCK) begin
        sysclk_r <= cfg_wdata;
      end else if (cfg_index == REG_OUTPUT_FREQ) begin
        freq_r <= cfg_wdata[FREQ_W-1:0];
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through divide, select, split by 100; restart on a write to index 0 or 1
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_LOAD:     state_nxt = SEQ_DIV_FREQ;
      SEQ_DIV_FREQ: if (cnt_r == DIV_LAST) state_nxt = SEQ_SELECT;
      SEQ_SELECT:   state_nxt = SEQ_DIV_HUND;
      SEQ_DIV_HUND: state_nxt = SEQ_STORE;
      SEQ_STORE:    state_nxt = SEQ_IDLE;
      SEQ_IDLE:     state_nxt = SEQ_IDLE;
      default:      state_nxt = SEQ_LOAD;
    endcase
    if (cfg_hit) state_nxt = SEQ_LOAD;
  end

  // One restoring division step per cycle
  assign divisor = freq_r;
  assign trial   = {rem_r, quo_r[QUOT_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign rem_nxt = fits ? FREQ_W'(trial - {1'b0, divisor}) : FREQ_W'(trial);

  // Pick the first prescaler whose period stays under the limit
  always_comb begin
    found   = 1'b0;
    exp_sel = '0;
    for (int d = 0; d < EXP_COUNT; d++) begin
      if (!found && CMP_W'(quo_r >> d) < LIMIT) begin
        found   = 1'b1;
        exp_sel = EXP_W'(d);
      end
    end
    steps_sel = STEP_W'(quo_r >> exp_sel);
  end

  // Split the period as 100*hi + lo: quotient first, remainder next cycle
  assign hund_prod = (2*QUOT_W)'(steps_r) * (2*QUOT_W)'(HUND_RECIP);
  assign hund_part = hi_r * STEP_W'(FULL_PERCENT);
  assign hund_rem  = steps_r - hund_part;

  // Divider datapath and stored selection
  always_ff @(posedge clk) begin
    unique case (state_r)
      SEQ_LOAD: begin
        quo_r <= sysclk_r[SYS_W-1:2];
        rem_r <= '0;
        cnt_r <= '0;
      end
      SEQ_DIV_FREQ: begin
        quo_r <= {quo_r[QUOT_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
      SEQ_SELECT: begin
        err_r   <= (freq_r == '0) || !found;
        exp_r   <= exp_sel;
        steps_r <= steps_sel;
      end
      SEQ_DIV_HUND: begin
        hi_r <= STEP_W'(hund_prod >> HUND_SHIFT);
      end
      SEQ_STORE: begin
        lo_r <= hund_rem[PCT_W-1:0];
      end
      SEQ_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign sel.busy = (state_r != SEQ_IDLE);
  assign sel.err  = err_r;
  assign sel.exp  = exp_r;
  assign steps    = steps_r;
  assign steps_hi = hi_r;
  assign steps_lo = lo_r;

endmodule

// ===== src/pwm_brightness_timer_setup_unit.sv =====
// PWM brightness timer setup.
// A request is taken on a rising edge with start high and busy low; it carries
// a signed brightness percent. At the end of the pipeline, out_valid pulses
// for one cycle with the prescaler exponent, period, compare level and error
// flag. When not busy, requests may be issued every cycle: the request path is
// a four stage pipeline (square, divide by 100, scale, divide and add) and
// sustains one request per cycle. The receiver cannot stall and no results are
// held. Configuration writes go through cfg_valid/cfg_ready (always ready),
// index 0 is the system clock in Hz, index 1 the output frequency in Hz. After
// reset and after each write to index 0 or 1, a setup engine runs a one bit
// per cycle long division of timer clock by frequency, picks the prescaler,
// then splits the period by 100 with a reciprocal multiply; busy stays high
// while it runs. Write configuration only while no request is in flight.
module pwm_brightness_timer_setup_unit import pbts_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [7:0]    in_brightness_percent,
  output logic                 out_valid,
  output logic [EXP_W-1:0]     out_prescale_exponent,
  output logic [FIELD_W-1:0]   out_period_steps,
  output logic [FIELD_W-1:0]   out_compare_level,
  output logic                 out_period_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int STEP_W = (COUNTER_BITS < QUOT_W) ? COUNTER_BITS : QUOT_W;
  localparam int SUM_W  = (STEP_W + PCT_W > FIELD_W) ? STEP_W + PCT_W : FIELD_W;
  localparam int PS_W   = (STEP_W > FIELD_W) ? STEP_W : FIELD_W;

  sel_info_t         sel;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] steps_hi;
  logic [PCT_W-1:0]  steps_lo;

  logic              accept;
  logic [PCT_W-1:0]  pct;
  logic [PS_W-1:0]   steps_ext;
  logic [SUM_W-1:0]  cmp_sum;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [SQ_W-1:0]   sq1_r;
  logic [PCT_W-1:0]  duty2_r;
  logic [SUM_W-1:0]  hi3_r;
  logic [SQ_W-1:0]   lo3_r;
  logic [EXP_W-1:0]  exp_out_r;
  logic [FIELD_W-1:0] steps_out_r;
  logic [FIELD_W-1:0] cmp_out_r;
  logic              err_out_r;

  pbts_setup #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sel      (sel),
    .steps    (steps),
    .steps_hi (steps_hi),
    .steps_lo (steps_lo)
  );

  assign busy      = sel.busy;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Clamp the percent to 0..100
  always_comb begin
    priority if (in_brightness_percent[7]) begin
      pct = '0;
    end else if (in_brightness_percent[PCT_W-1:0] > FULL_PERCENT) begin
      pct = FULL_PERCENT;
    end else begin
      pct = in_brightness_percent[PCT_W-1:0];
    end
  end

  // Move valid bits down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage math: square, perceptual duty, scale by period split as 100*hi + lo
  assign steps_ext = PS_W'(steps);
  assign cmp_sum   = hi3_r + SUM_W'(div100(lo3_r));

  always_ff @(posedge clk) begin
    sq1_r   <= SQ_W'(pct) * SQ_W'(pct);
    duty2_r <= div100(sq1_r);
    hi3_r   <= SUM_W'(steps_hi) * SUM_W'(duty2_r);
    lo3_r   <= SQ_W'(steps_lo) * SQ_W'(duty2_r);
    if (sel.err) begin
      exp_out_r   <= '0;
      steps_out_r <= '0;
      cmp_out_r   <= '0;
      err_out_r   <= 1'b1;
    end else begin
      exp_out_r   <= sel.exp;
      steps_out_r <= steps_ext[FIELD_W-1:0];
      cmp_out_r   <= cmp_sum[FIELD_W-1:0];
      err_out_r   <= 1'b0;
    end
  end

  assign out_valid             = v4_r;
  assign out_prescale_exponent = exp_out_r;
  assign out_period_steps      = steps_out_r;
  assign out_compare_level     = cmp_out_r;
  assign out_period_error      = err_out_r;

  // Every accepted request yields a result at the end of the pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("accepted request produced no result");

  // An error result carries zeroed settings
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_error |->
      out_prescale_exponent == '0 && out_period_steps == '0 && out_compare_level == '0)
    else $error("error result with nonzero settings");

  // The compare level never exceeds the period when COUNTER_BITS <= FIELD_W
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (COUNTER_BITS <= FIELD_W) |-> out_compare_level <= out_period_steps)
    else $error("compare level above period");

endmodule

// ===== tb/sv/pwm_brightness_timer_setup_unit_checker.sv =====
`timescale 1ns / 1ps

module pwm_brightness_timer_setup_unit_checker import pbts_pkg::*; #(
  parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [7:0]    in_brightness_percent,
  input  logic                 out_valid,
  input  logic [EXP_W-1:0]     out_prescale_exponent,
  input  logic [FIELD_W-1:0]   out_period_steps,
  input  logic [FIELD_W-1:0]   out_compare_level,
  input  logic                 out_period_error,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   results_checked,
  output int                   error_results
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [EXP_W-1:0]   exponent;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] compare;
    logic               err;
  } timer_setting_t;

  // Shadow copy of the two setup registers
  logic [SYS_W-1:0]  sys_clock_hz;
  logic [FREQ_W-1:0] pwm_freq_hz;

  timer_setting_t expected_settings[$];
  int fails;
  int waiting;
  int checked;
  int flagged;

  assign fail_count      = fails;
  assign pending         = waiting;
  assign results_checked = checked;
  assign error_results   = flagged;

  // Work out the timer setting for one brightness request
  function automatic timer_setting_t timer_setting_for(input logic signed [7:0] pct_in);
    logic [63:0] pct;
    logic [63:0] duty;
    logic [63:0] timer_clk;
    logic [63:0] steps;
    logic [63:0] step_limit;
    logic [63:0] candidate;
    logic [EXP_W-1:0] chosen;
    bit found;
    timer_setting_t res;
    res = '0;
    found = 1'b0;
    steps = '0;
    chosen = '0;
    step_limit = (64'd1 << COUNTER_BITS) - 64'd1;
    // clamp to 0..100, then square for perceived brightness
    if (pct_in < 0)
      pct = '0;
    else if (pct_in > FULL_PERCENT)
      pct = 64'(FULL_PERCENT);
    else
      pct = {56'd0, pct_in};
    duty = (pct * pct) / FULL_PERCENT;
    timer_clk = 64'(sys_clock_hz) / 64'd4;
    // take the smallest prescaler that keeps the period under the counter limit
    if (pwm_freq_hz != '0) begin
      for (int d = 0; ((1 << d) < PRESCALE_LIMIT) && !found; d++) begin
        candidate = (timer_clk >> d) / 64'(pwm_freq_hz);
        if (candidate < step_limit) begin
          steps = candidate;
          chosen = EXP_W'(d);
          found = 1'b1;
        end
      end
    end
    if (found) begin
      res.exponent = chosen;
      res.period   = FIELD_W'(steps);
      res.compare  = FIELD_W'((steps * duty) / FULL_PERCENT);
      res.err      = 1'b0;
    end else begin
      res.err = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track_requests
    timer_setting_t want;
    timer_setting_t got;
    if (!rst_n) begin
      sys_clock_hz = SYS_CLOCK_RESET;
      pwm_freq_hz  = OUT_FREQ_RESET;
      expected_settings.delete();
    end else begin
      // follow register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SYSTEM_CLOCK)
          sys_clock_hz = cfg_wdata[SYS_W-1:0];
        else if (cfg_index == REG_OUTPUT_FREQ)
          pwm_freq_hz = cfg_wdata[FREQ_W-1:0];
      end
      // predict each accepted request
      if (start && !busy)
        expected_settings.push_back(timer_setting_for(in_brightness_percent));
      // compare each result with the oldest prediction
      if (out_valid) begin
        got = {out_prescale_exponent, out_period_steps, out_compare_level, out_period_error};
        if (got.err === 1'b1)
          flagged++;
        if (expected_settings.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result with no request waiting: exp=%0d period=%0d compare=%0d err=%0b",
                     $realtime, got.exponent, got.period, got.compare, got.err);
        end else begin
          want = expected_settings.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("%0t: timer setting mismatch: expected exp=%0d period=%0d compare=%0d err=%0b, got exp=%0d period=%0d compare=%0d err=%0b",
                       $realtime, want.exponent, want.period, want.compare, want.err,
                       got.exponent, got.period, got.compare, got.err);
          end
        end
      end
    end
    waiting = expected_settings.size();
  end

endmodule

// ===== tb/sv/pwm_brightness_timer_setup_unit_tb.sv =====
`timescale 1ns / 1ps

module pwm_brightness_timer_setup_unit_tb;
  import pbts_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int RESET_CYCLES      = 12;
  localparam int DIRECTED_SETTINGS = 12;
  localparam int RANDOM_SETTINGS   = 8;
  localparam int REQS_PER_SETTING  = 92;
  localparam int IDLE_HEAVY        = 68;
  localparam int IDLE_LIGHT        = 38;
  localparam int SETTLE_CYCLES     = 6;
  localparam int DRAIN_LIMIT       = 2000;
  localparam longint unsigned STEP_LIMIT = (64'd1 << DEF_COUNTER_BITS) - 1;

  // Indexes the block does not map
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [7:0]    in_brightness_percent;
  logic                 out_valid;
  logic [EXP_W-1:0]     out_prescale_exponent;
  logic [FIELD_W-1:0]   out_period_steps;
  logic [FIELD_W-1:0]   out_compare_level;
  logic                 out_period_error;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending;
  int results_checked;
  int error_results;
  int n_requests;
  int n_writes;
  int n_settings;
  int idle_pct;
  int cycle_count;

  pwm_brightness_timer_setup_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_brightness_percent (in_brightness_percent),
    .out_valid             (out_valid),
    .out_prescale_exponent (out_prescale_exponent),
    .out_period_steps      (out_period_steps),
    .out_compare_level     (out_compare_level),
    .out_period_error      (out_period_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  pwm_brightness_timer_setup_unit_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_brightness_percent (in_brightness_percent),
    .out_valid             (out_valid),
    .out_prescale_exponent (out_prescale_exponent),
    .out_period_steps      (out_period_steps),
    .out_compare_level     (out_compare_level),
    .out_period_error      (out_period_error),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .fail_count            (fail_count),
    .pending               (pending),
    .results_checked       (results_checked),
    .error_results         (error_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles without finishing", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Issue one brightness request, with random idle cycles ahead of it
  task automatic send_request(input logic signed [7:0] pct);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_brightness_percent <= 8'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_brightness_percent <= pct;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_requests++;
  endtask

  // Hold off until every outstanding request has returned
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] word);
    while (busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
    n_writes++;
    // let the setup engine raise busy before anything else goes in
    repeat (2) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] sys_hz, input logic [CFG_W-1:0] freq_word);
    wait_for_results();
    write_reg(REG_SYSTEM_CLOCK, sys_hz);
    write_reg(REG_OUTPUT_FREQ, freq_word);
    n_settings++;
  endtask

  // Corner settings: extremes, exact counter limit at d=0 and d=7, zero frequency
  task automatic directed_setting(input int k, output logic [CFG_W-1:0] sys_hz,
                                  output logic [CFG_W-1:0] freq_word);
    case (k)
      0:       begin sys_hz = 28'd200000000; freq_word = 28'd1000000; end
      1:       begin sys_hz = 28'd3;         freq_word = 28'd7;       end
      2:       begin sys_hz = 28'd0;         freq_word = 28'd1000;    end
      3:       begin sys_hz = 28'd33553920;  freq_word = 28'd1;       end
      4:       begin sys_hz = 28'd33553916;  freq_word = 28'd1;       end
      5:       begin sys_hz = 28'd48000000;  freq_word = 28'd0;       end
      6:       begin sys_hz = 28'hfffffff;   freq_word = 28'hfffff;   end
      7:       begin sys_hz = 28'd4;         freq_word = 28'd1;       end
      8:       begin sys_hz = 28'hfffffff;   freq_word = 28'd1;       end
      9:       begin sys_hz = 28'd262140;    freq_word = 28'd1;       end
      10:      begin sys_hz = 28'd262136;    freq_word = 28'd1;       end
      default: begin sys_hz = SYS_CLOCK_RESET; freq_word = CFG_W'(OUT_FREQ_RESET); end
    endcase
  endtask

  task automatic random_setting(output logic [CFG_W-1:0] sys_hz, output logic [CFG_W-1:0] freq_word);
    logic [CFG_W-1:0] timer_clk;
    longint unsigned f;
    int k;
    case ($urandom_range(3))
      0:       sys_hz = CFG_W'($urandom);
      1:       sys_hz = CFG_W'($urandom_range(200000000, 1));
      2:       sys_hz = CFG_W'($urandom_range(4000, 1));
      default: sys_hz = CFG_W'($urandom_range(100000000, 20000000));
    endcase
    timer_clk = sys_hz >> 2;
    if ($urandom_range(1)) begin
      // aim the period at the counter limit for one prescaler step
      k = $urandom_range(EXP_COUNT - 1);
      f = (longint'(timer_clk) >> k) / STEP_LIMIT + $urandom_range(2);
    end else begin
      k = $urandom_range(FREQ_W, 1);
      f = ($urandom & ((1 << k) - 1)) | (1 << (k - 1));
    end
    if (f == 0)
      f = 1;
    freq_word = CFG_W'(f[FREQ_W-1:0]);
    if ($urandom_range(3) == 0)
      freq_word[CFG_W-1:FREQ_W] = (CFG_W-FREQ_W)'($urandom);
  endtask

  function automatic logic [7:0] random_percent();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'($urandom_range(100));
      5: begin
        case ($urandom_range(7))
          0:       return 8'h80;
          1:       return 8'hff;
          2:       return 8'd0;
          3:       return 8'd1;
          4:       return 8'd99;
          5:       return 8'd100;
          6:       return 8'd101;
          default: return 8'h7f;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // One block of random requests under a fixed setting
  task automatic run_phase(input int phase);
    int pause_at;
    pause_at = $urandom_range(REQS_PER_SETTING - 1);
    case (phase % 4)
      1:       idle_pct = IDLE_HEAVY;
      3:       idle_pct = IDLE_LIGHT;
      default: idle_pct = 0;
    endcase
    for (int i = 0; i < REQS_PER_SETTING; i++) begin
      if (i == pause_at)
        wait_for_results();
      send_request(random_percent());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sys_hz;
    logic [CFG_W-1:0] freq_word;
    int guard;
    rst_n = 1'b0;
    start = 1'b0;
    in_brightness_percent = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SYSTEM_CLOCK;
    cfg_wdata = '0;
    idle_pct = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // percent extremes under the reset setting
    send_request(-8'sd128);
    send_request(-8'sd1);
    send_request(8'sd0);
    send_request(8'sd1);
    send_request(8'sd9);
    send_request(8'sd10);
    send_request(8'sd50);
    send_request(8'sd85);
    send_request(8'sd42);
    send_request(8'sd99);
    send_request(8'sd100);
    send_request(8'sd101);
    send_request(8'sd127);

    // writes to unmapped indexes must leave the setting alone
    wait_for_results();
    write_reg(REG_UNMAPPED_LO, CFG_W'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_W'($urandom));
    send_request(8'sd77);

    for (int p = 0; p < DIRECTED_SETTINGS + RANDOM_SETTINGS; p++) begin
      if (p < DIRECTED_SETTINGS)
        directed_setting(p, sys_hz, freq_word);
      else
        random_setting(sys_hz, freq_word);
      apply_setting(sys_hz, freq_word);
      run_phase(p);
    end

    // drain the pipeline
    start <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);

    $display("Sent %0d brightness requests under %0d timer settings (%0d register writes).",
             n_requests, n_settings + 1, n_writes);
    $display("Checked %0d results, %0d of them flagged with a period error.",
             results_checked, error_results);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
